// ===== hw/rtl/tts_pkg.sv =====
`timescale 1ns / 1ps

package tts_pkg;

    // Command codes carried in the mode field
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_ADD      = 2'd1;
    localparam logic [1:0] MODE_DELETE   = 2'd2;
    localparam logic [1:0] MODE_DISPATCH = 2'd3;

    // At most this many run results per dispatch command
    localparam int RESULT_LIMIT = 16;
    localparam int RES_CNT_W    = $clog2(RESULT_LIMIT + 1);

    localparam logic [7:0] PEND_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] task_tag;
        logic [31:0] start_delay;
        logic [31:0] period;
        logic [3:0]  slot;
    } tts_cmd_t;

    typedef struct packed {
        logic [3:0]  slot_out;
        logic [15:0] tag_out;
        logic        run_valid;
        logic        table_full;
        logic        last;
    } tts_res_t;

    // One table entry as held in the slot RAM (used marks live in flops)
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pend;
    } tts_entry_t;

    // Slot update decision from the per-slot unit
    typedef struct packed {
        logic       wr;
        logic       emit;
        logic       free;
        tts_entry_t entry;
    } tts_upd_t;

endpackage

// ===== hw/rtl/tick_task_timer_scheduler.sv =====
`timescale 1ns / 1ps

// Tick task timer scheduler: a table of MAX_TASKS timer slots in a RAM.
// Command channel: cmd is taken at a clock edge with start high and busy low.
// cmd.mode picks tick, add, delete or dispatch.
// Result channel: res holds one result for the single cycle res_strobe is
// high; the receiver has no back pressure and must take it then.
// Add and delete: one result the cycle after the command, busy stays low,
// so these can be issued every cycle.
// Tick and dispatch: walk the slot RAM one slot per cycle (read, update,
// write back). busy stays high through the walk and the finishing state,
// and the final result shows in the cycle busy falls; no new command is
// taken while busy. The single RAM read port paces the walk. Dispatch
// gives one result per slot with pending runs (at most 16), in slot
// order; last marks the final one.
// A dispatch with nothing due, and every tick, give one empty result with
// last set. Because the last flag needs look-ahead, each run result is held
// until the next one is found or the walk ends.
// Reset clears all used marks at once; the RAM contents only matter for
// used slots, so no clearing pass is needed.

module tick_task_timer_scheduler
    import tts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  tts_cmd_t cmd,
    output logic     res_strobe,
    output tts_res_t res
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    function automatic logic [3:0] to_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W+3:0] e;
        e = {4'b0, i};
        return e[3:0];
    endfunction

    // control state
    logic [1:0]           state_reg, state_next;
    logic                 is_tick_reg, is_tick_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 s1_vld_reg, s1_vld_next;
    logic [IDX_W-1:0]     s1_idx_reg, s1_idx_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 hold_vld_reg, hold_vld_next;
    logic                 res_strobe_reg, res_strobe_next;
    logic [MAX_TASKS-1:0] used_reg, used_next;

    // payload
    tts_res_t             hold_reg, hold_next;
    tts_res_t             res_reg, res_next;

    // RAM ports
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    tts_entry_t           mem_wdata;
    logic                 mem_rd_en;
    tts_entry_t           mem_rdata;

    tts_upd_t             upd;
    logic                 accept;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W+3:0]     del_ext;
    logic                 del_in_range;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign del_ext      = {{IDX_W{1'b0}}, cmd.slot};
    assign del_in_range = (32'(cmd.slot) < MAX_TASKS);

    tts_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rd_en (mem_rd_en),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    tts_slot_alu u_alu (
        .is_tick (is_tick_reg),
        .used    (used_reg[s1_idx_reg]),
        .room    (res_cnt_reg < RES_CNT_W'(RESULT_LIMIT)),
        .entry   (mem_rdata),
        .upd     (upd)
    );

    always_comb
    begin
        state_next      = state_reg;
        is_tick_next    = is_tick_reg;
        rd_idx_next     = rd_idx_reg;
        s1_vld_next     = 1'b0;
        s1_idx_next     = s1_idx_reg;
        res_cnt_next    = res_cnt_reg;
        hold_vld_next   = hold_vld_reg;
        hold_next       = hold_reg;
        res_strobe_next = 1'b0;
        res_next        = res_reg;
        used_next       = used_reg;
        mem_we          = 1'b0;
        mem_waddr       = s1_idx_reg;
        mem_wdata       = upd.entry;
        mem_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_strobe_next = 1'b1;
                    res_next        = '0;
                    res_next.last   = 1'b1;
                    case (cmd.mode)
                        MODE_ADD:
                        begin
                            if (free_found)
                            begin
                                mem_we               = 1'b1;
                                mem_waddr            = free_idx;
                                mem_wdata.tag        = cmd.task_tag;
                                mem_wdata.delay      = cmd.start_delay;
                                mem_wdata.period     = cmd.period;
                                mem_wdata.pend       = 8'd0;
                                used_next[free_idx]  = 1'b1;
                                res_next.slot_out    = to_slot(free_idx);
                            end
                            else
                            begin
                                res_next.table_full = 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (del_in_range)
                            begin
                                used_next[del_ext[IDX_W-1:0]] = 1'b0;
                            end
                        end
                        default:
                        begin
                            // tick or dispatch: start the slot walk
                            res_strobe_next = 1'b0;
                            is_tick_next    = (cmd.mode == MODE_TICK);
                            rd_idx_next     = '0;
                            res_cnt_next    = '0;
                            hold_vld_next   = 1'b0;
                            state_next      = ST_WALK;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // read stage
                if (rd_idx_reg < CNT_W'(MAX_TASKS))
                begin
                    mem_rd_en   = 1'b1;
                    s1_vld_next = 1'b1;
                    s1_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                // update and write-back stage
                if (s1_vld_reg)
                begin
                    mem_we = upd.wr;
                    if (upd.free)
                    begin
                        used_next[s1_idx_reg] = 1'b0;
                    end
                    if (upd.emit)
                    begin
                        res_cnt_next = res_cnt_reg + RES_CNT_W'(1);
                        if (hold_vld_reg)
                        begin
                            res_strobe_next = 1'b1;
                            res_next        = hold_reg;
                        end
                        hold_vld_next       = 1'b1;
                        hold_next           = '0;
                        hold_next.slot_out  = to_slot(s1_idx_reg);
                        hold_next.tag_out   = mem_rdata.tag;
                        hold_next.run_valid = 1'b1;
                    end
                    if (s1_idx_reg == IDX_W'(MAX_TASKS - 1))
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                res_strobe_next = 1'b1;
                if (hold_vld_reg)
                begin
                    res_next = hold_reg;
                end
                else
                begin
                    res_next = '0;
                end
                res_next.last = 1'b1;
                hold_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            is_tick_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            s1_vld_reg     <= 1'b0;
            s1_idx_reg     <= '0;
            res_cnt_reg    <= '0;
            hold_vld_reg   <= 1'b0;
            res_strobe_reg <= 1'b0;
            used_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            is_tick_reg    <= is_tick_next;
            rd_idx_reg     <= rd_idx_next;
            s1_vld_reg     <= s1_vld_next;
            s1_idx_reg     <= s1_idx_next;
            res_cnt_reg    <= res_cnt_next;
            hold_vld_reg   <= hold_vld_next;
            res_strobe_reg <= res_strobe_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    assign res_strobe = res_strobe_reg;
    assign res        = res_reg;

`ifndef ASSERT_OFF
    a_run_not_full : assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> !(res.run_valid && res.table_full))
        else $error("run and full flags both set");

    a_nonlast_is_run : assert property (@(posedge clk) disable iff (!rst_n)
        (res_strobe && !res.last) |-> res.run_valid)
        else $error("non-final result that names no task");

    a_res_limit : assert property (@(posedge clk) disable iff (!rst_n)
        res_cnt_reg <= RES_CNT_W'(RESULT_LIMIT))
        else $error("dispatch result count above limit");

    a_walk_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg && s1_idx_reg == IDX_W'(MAX_TASKS - 1)) |=> state_reg == ST_FIN)
        else $error("walk did not finish after last slot");
`endif

endmodule

// ===== hw/rtl/tts_mem.sv =====
`timescale 1ns / 1ps

module tts_mem
    import tts_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  tts_entry_t       wdata,
    input  logic             rd_en,
    input  logic [AW-1:0]    raddr,
    output tts_entry_t       rdata
);

    tts_entry_t mem [DEPTH];
    tts_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tts_slot_alu.sv =====
`timescale 1ns / 1ps

module tts_slot_alu
    import tts_pkg::*;
(
    input  logic       is_tick,
    input  logic       used,
    input  logic       room,
    input  tts_entry_t entry,
    output tts_upd_t   upd
);

    always_comb
    begin
        upd       = '0;
        upd.entry = entry;
        if (is_tick)
        begin
            upd.wr = used;
            if (entry.delay == 32'd0)
            begin
                if (entry.pend != PEND_MAX)
                begin
                    upd.entry.pend = entry.pend + 8'd1;
                end
                if (entry.period != 32'd0)
                begin
                    upd.entry.delay = entry.period;
                end
            end
            else
            begin
                upd.entry.delay = entry.delay - 32'd1;
            end
        end
        else
        begin
            // dispatch: one run taken off, one-shot slots freed
            upd.emit       = used && (entry.pend != 8'd0) && room;
            upd.wr         = upd.emit;
            upd.entry.pend = entry.pend - 8'd1;
            upd.free       = upd.emit && (entry.period == 32'd0);
        end
    end

endmodule
